// ----- rtl/core/trajectory_smoothing_correction_top_defines.svh -----
// ---------------------------------------------------------------------------
// trajectory smoothing correction: assertion macros
// shared property forms, clocked on clk_i and disabled while rst_ni is low
// ---------------------------------------------------------------------------
`ifndef TRAJECTORY_SMOOTHING_CORRECTION_TOP_DEFINES_SVH
`define TRAJECTORY_SMOOTHING_CORRECTION_TOP_DEFINES_SVH

// same-cycle implication
`define TSC_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/tsc_pkg.sv -----
// ---------------------------------------------------------------------------
// tsc_pkg
// widths, register codes and the sequencer microcode for trajectory smoothing
// ---------------------------------------------------------------------------
package tsc_pkg;

  localparam int unsigned RING_DEPTH_DEF = 64;

  localparam int unsigned DATA_W  = 24;  // x / y shift and lane data width
  localparam int unsigned ANGLE_W = 20;
  localparam int unsigned BL_W    = 7;
  localparam int unsigned SR_W    = 6;
  localparam int unsigned DIV_W   = SR_W + 1;  // window size up to 2**SR_W

  localparam logic [BL_W-1:0] BL_RESET = BL_W'(60);
  localparam logic [SR_W-1:0] SR_RESET = SR_W'(50);

  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  // register index, taken from paddr[2]
  localparam logic REG_BUFFER_LENGTH    = 1'b0;
  localparam logic REG_SMOOTHING_RADIUS = 1'b1;

  localparam int unsigned STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_LOAD    = 4'd0;
  localparam logic [STEP_W-1:0] STEP_SETUP   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_WALK    = 4'd2;
  localparam logic [STEP_W-1:0] STEP_FLUSH   = 4'd3;
  localparam logic [STEP_W-1:0] STEP_DIVINIT = 4'd4;
  localparam logic [STEP_W-1:0] STEP_DIVSTEP = 4'd5;
  localparam logic [STEP_W-1:0] STEP_SIGN    = 4'd6;
  localparam logic [STEP_W-1:0] STEP_SUM     = 4'd7;
  localparam logic [STEP_W-1:0] STEP_EMIT    = 4'd8;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_SETUP,
    OP_ACC,
    OP_FLUSH,
    OP_DIVINIT,
    OP_DIVSTEP,
    OP_SIGN,
    OP_SUM,
    OP_EMIT
  } op_e;

  // stay on the current step while the condition holds
  typedef enum logic [2:0] {
    H_NONE,
    H_NO_INPUT,
    H_WALK_MORE,
    H_DIV_MORE,
    H_OUT_BUSY
  } hold_e;

  typedef struct packed {
    op_e               op;
    hold_e             hold;
    logic              jump;
    logic [STEP_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic load;
    logic acc;
    logic tail;
    logic flush;
    logic div_init;
    logic div_step;
    logic sign;
    logic sum;
  } lane_ctl_t;

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '{op: OP_NOP, hold: H_NONE, jump: 1'b1, target: STEP_LOAD};
    unique case (step)
      STEP_LOAD:    w = '{op: OP_LOAD,    hold: H_NO_INPUT,  jump: 1'b0, target: STEP_LOAD};
      STEP_SETUP:   w = '{op: OP_SETUP,   hold: H_NONE,      jump: 1'b0, target: STEP_LOAD};
      STEP_WALK:    w = '{op: OP_ACC,     hold: H_WALK_MORE, jump: 1'b0, target: STEP_LOAD};
      STEP_FLUSH:   w = '{op: OP_FLUSH,   hold: H_NONE,      jump: 1'b0, target: STEP_LOAD};
      STEP_DIVINIT: w = '{op: OP_DIVINIT, hold: H_NONE,      jump: 1'b0, target: STEP_LOAD};
      STEP_DIVSTEP: w = '{op: OP_DIVSTEP, hold: H_DIV_MORE,  jump: 1'b0, target: STEP_LOAD};
      STEP_SIGN:    w = '{op: OP_SIGN,    hold: H_NONE,      jump: 1'b0, target: STEP_LOAD};
      STEP_SUM:     w = '{op: OP_SUM,     hold: H_NONE,      jump: 1'b0, target: STEP_LOAD};
      STEP_EMIT:    w = '{op: OP_EMIT,    hold: H_OUT_BUSY,  jump: 1'b1, target: STEP_LOAD};
      default:      w = '{op: OP_NOP,     hold: H_NONE,      jump: 1'b1, target: STEP_LOAD};
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/core/tsc_motion_if.sv -----
// ---------------------------------------------------------------------------
// tsc_motion_if
// request channel carrying one frame-to-frame motion estimate
// ---------------------------------------------------------------------------
interface tsc_motion_if;
  logic                                valid;
  logic                                ready;
  logic signed [tsc_pkg::DATA_W-1:0]   shift_x;
  logic signed [tsc_pkg::DATA_W-1:0]   shift_y;
  logic signed [tsc_pkg::ANGLE_W-1:0]  turn_angle;

  modport source (output valid, output shift_x, output shift_y, output turn_angle,
                  input ready);
  modport sink   (input valid, input shift_x, input shift_y, input turn_angle,
                  output ready);
endinterface

// ----- rtl/core/tsc_corr_if.sv -----
// ---------------------------------------------------------------------------
// tsc_corr_if
// request channel carrying one smoothed motion correction
// ---------------------------------------------------------------------------
interface tsc_corr_if;
  logic                                valid;
  logic                                ready;
  logic signed [tsc_pkg::DATA_W-1:0]   corrected_x;
  logic signed [tsc_pkg::DATA_W-1:0]   corrected_y;
  logic signed [tsc_pkg::ANGLE_W-1:0]  corrected_angle;

  modport source (output valid, output corrected_x, output corrected_y,
                  output corrected_angle, input ready);
  modport sink   (input valid, input corrected_x, input corrected_y,
                  input corrected_angle, output ready);
endinterface

// ----- rtl/core/tsc_lane.sv -----
// ---------------------------------------------------------------------------
// tsc_lane
// one motion component: trajectory walk, window sum, serial divide, saturate
// ---------------------------------------------------------------------------
module tsc_lane #(
  parameter int unsigned ACC_W = 30,
  parameter int unsigned SUM_W = 36,
  parameter int unsigned OUT_W = 24
) (
  input  logic                              clk_i,
  input  tsc_pkg::lane_ctl_t                ctl_i,
  input  logic signed [tsc_pkg::DATA_W-1:0] new_data_i,
  input  logic signed [tsc_pkg::DATA_W-1:0] ring_data_i,
  input  logic [tsc_pkg::DIV_W-1:0]         div_n_i,
  output logic signed [OUT_W-1:0]           result_o
);

  localparam int unsigned DW    = tsc_pkg::DATA_W;
  localparam int unsigned NW    = tsc_pkg::DIV_W;
  localparam int unsigned RES_W = SUM_W + 2;

  logic signed [DW-1:0]    new_q;
  logic signed [ACC_W-1:0] traj_q;
  logic signed [SUM_W-1:0] sum_q;
  logic                    tail_q;
  logic signed [ACC_W:0]   diff_q;
  logic [SUM_W-1:0]        quo_q;
  logic [NW-1:0]           rem_q;
  logic                    neg_q;
  logic signed [SUM_W:0]   qs_q;
  logic signed [RES_W-1:0] res_q;

  logic signed [ACC_W-1:0] ring_ext;
  logic signed [SUM_W-1:0] traj_add;
  logic [NW:0]             shifted;
  logic [NW:0]             trial;
  logic                    fits;
  logic [SUM_W-1:0]        mag;
  logic                    in_range;

  assign ring_ext = {{(ACC_W-DW){ring_data_i[DW-1]}}, ring_data_i};
  // trajectory point of the previous entry joins the sum once inside the window
  assign traj_add = tail_q ? {{(SUM_W-ACC_W){traj_q[ACC_W-1]}}, traj_q} : '0;

  // restoring divide, one quotient bit per step
  assign shifted = {rem_q, quo_q[SUM_W-1]};
  assign trial   = shifted - {1'b0, div_n_i};
  assign fits    = ~trial[NW];
  assign mag     = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      new_q  <= new_data_i;
      traj_q <= '0;
      sum_q  <= '0;
      tail_q <= 1'b0;
    end else if (ctl_i.acc) begin
      traj_q <= traj_q + ring_ext;
      tail_q <= ctl_i.tail;
      sum_q  <= sum_q + traj_add;
    end else if (ctl_i.flush) begin
      sum_q  <= sum_q + traj_add;
      diff_q <= {{(ACC_W+1-DW){new_q[DW-1]}}, new_q} - {traj_q[ACC_W-1], traj_q};
    end else if (ctl_i.div_init) begin
      quo_q <= mag;
      rem_q <= '0;
      neg_q <= sum_q[SUM_W-1];
    end else if (ctl_i.div_step) begin
      quo_q <= {quo_q[SUM_W-2:0], fits};
      rem_q <= fits ? trial[NW-1:0] : shifted[NW-1:0];
    end else if (ctl_i.sign) begin
      qs_q <= neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
    end else if (ctl_i.sum) begin
      res_q <= {{(RES_W-ACC_W-1){diff_q[ACC_W]}}, diff_q} + {qs_q[SUM_W], qs_q};
    end
  end

  assign in_range = (&res_q[RES_W-1:OUT_W-1]) | ~(|res_q[RES_W-1:OUT_W-1]);

  always_comb begin
    if (in_range) begin
      result_o = res_q[OUT_W-1:0];
    end else if (res_q[RES_W-1]) begin
      result_o = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      result_o = {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

endmodule

// ----- rtl/core/trajectory_smoothing_correction_top.sv -----
// ---------------------------------------------------------------------------
// trajectory_smoothing_correction_top
// moving-average trajectory smoothing over a ring of motion estimates
// ---------------------------------------------------------------------------
// sequence per request: setup, walk over the stored entries, flush, divide init,
// a bit-serial divide of SUM_W = 24 + clog2(RING_DEPTH) + 6 quotient bits (36 at
// depth 64), sign, sum and emit; emit waits while the last result is not taken,
// and a new request is accepted only after the result of the last one is emitted
// reset: stored count and write slot clear, buffer_length 60, radius 50,
// ring contents are left unset and are never used before they are written
// ---------------------------------------------------------------------------
`include "trajectory_smoothing_correction_top_defines.svh"

module trajectory_smoothing_correction_top #(
  parameter int unsigned RING_DEPTH = tsc_pkg::RING_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  tsc_motion_if.sink                  motion_i,
  tsc_corr_if.source                  corr_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tsc_pkg::APB_AW-1:0]  paddr,
  input  logic [tsc_pkg::APB_DW-1:0]  pwdata,
  output logic [tsc_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int unsigned DW     = tsc_pkg::DATA_W;
  localparam int unsigned AWID   = tsc_pkg::ANGLE_W;
  localparam int unsigned BLW    = tsc_pkg::BL_W;
  localparam int unsigned SRW    = tsc_pkg::SR_W;
  localparam int unsigned NW     = tsc_pkg::DIV_W;
  localparam int unsigned SW     = tsc_pkg::STEP_W;
  localparam int unsigned AW     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int unsigned CMP_W  = (CNT_W > BLW) ? CNT_W + 1 : BLW + 1;
  localparam int unsigned ACC_W  = DW + $clog2(RING_DEPTH);
  localparam int unsigned SUM_W  = ACC_W + SRW;
  localparam int unsigned SUMC_W = $clog2(SUM_W);
  localparam int unsigned KW     = (AW > SUMC_W) ? AW : SUMC_W;

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] a;
  } entry_t;

  // configuration
  logic [BLW-1:0] bl_q;
  logic [SRW-1:0] sr_q;
  logic           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bl_q <= tsc_pkg::BL_RESET;
      sr_q <= tsc_pkg::SR_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        tsc_pkg::REG_BUFFER_LENGTH:    bl_q <= pwdata[BLW-1:0];
        tsc_pkg::REG_SMOOTHING_RADIUS: sr_q <= pwdata[SRW-1:0];
        default:                       bl_q <= bl_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      tsc_pkg::REG_BUFFER_LENGTH:    prdata = tsc_pkg::APB_DW'(bl_q);
      tsc_pkg::REG_SMOOTHING_RADIUS: prdata = tsc_pkg::APB_DW'(sr_q);
      default:                       prdata = '0;
    endcase
  end

  // sequencer
  logic [SW-1:0]      step_q, step_d;
  tsc_pkg::ucode_t    uc;
  logic [KW-1:0]      k_q;
  logic [CNT_W-1:0]   count_q;
  logic [AW-1:0]      ws_q;
  logic [AW-1:0]      ptr_q;
  logic [CNT_W-1:0]   tail_start_q;
  logic [NW-1:0]      n_q;
  logic               out_valid_q;

  logic               accept;
  logic               walk_more;
  logic               div_more;
  logic               out_busy;
  logic               emit_fire;
  logic               hold;

  assign uc = tsc_pkg::ucode_rom(step_q);

  assign motion_i.ready = (uc.op == tsc_pkg::OP_LOAD);
  assign accept    = motion_i.valid & motion_i.ready;
  assign walk_more = (CMP_W'(k_q) + CMP_W'(1)) != CMP_W'(count_q);
  assign div_more  = k_q != KW'(SUM_W - 1);
  assign out_busy  = out_valid_q & ~corr_o.ready;
  assign emit_fire = (uc.op == tsc_pkg::OP_EMIT) & ~out_busy;

  always_comb begin
    unique case (uc.hold)
      tsc_pkg::H_NONE:      hold = 1'b0;
      tsc_pkg::H_NO_INPUT:  hold = ~motion_i.valid;
      tsc_pkg::H_WALK_MORE: hold = walk_more;
      tsc_pkg::H_DIV_MORE:  hold = div_more;
      tsc_pkg::H_OUT_BUSY:  hold = out_busy;
      default:              hold = 1'b0;
    endcase
    if (hold) begin
      step_d = step_q;
    end else if (uc.jump) begin
      step_d = uc.target;
    end else begin
      step_d = step_q + SW'(1);
    end
  end

  // length clamp and window bookkeeping
  logic [CMP_W-1:0] len_c;
  logic [CMP_W-1:0] cnt_inc;
  logic [CMP_W-1:0] rad_inc;
  logic [CMP_W-1:0] n_c;
  logic [AW:0]      first_raw;
  logic [AW-1:0]    first_c;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    rd_next;
  logic [AW-1:0]    ws_next;

  always_comb begin
    if (bl_q == '0) begin
      len_c = CMP_W'(1);
    end else if (CMP_W'(bl_q) > CMP_W'(RING_DEPTH)) begin
      len_c = CMP_W'(RING_DEPTH);
    end else begin
      len_c = CMP_W'(bl_q);
    end
  end

  // old entries beyond len-1 drop out, then the new one is counted
  assign cnt_inc = CMP_W'(count_q) + CMP_W'(1);
  assign rad_inc = CMP_W'(sr_q) + CMP_W'(1);
  assign n_c     = (rad_inc > CMP_W'(count_q)) ? CMP_W'(count_q) : rad_inc;

  assign first_raw = (AW+1)'(ws_q) + (AW+1)'(RING_DEPTH) - (AW+1)'(count_q);
  assign first_c   = (first_raw >= (AW+1)'(RING_DEPTH)) ?
                     AW'(first_raw - (AW+1)'(RING_DEPTH)) : AW'(first_raw);

  assign ws_next = (ws_q == AW'(RING_DEPTH - 1)) ? '0 : ws_q + AW'(1);
  assign rd_addr = (uc.op == tsc_pkg::OP_SETUP) ? first_c : ptr_q;
  assign rd_next = (rd_addr == AW'(RING_DEPTH - 1)) ? '0 : rd_addr + AW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q       <= tsc_pkg::STEP_LOAD;
      k_q          <= '0;
      count_q      <= '0;
      ws_q         <= '0;
      ptr_q        <= '0;
      tail_start_q <= '0;
      n_q          <= '0;
    end else begin
      step_q <= step_d;
      unique case (uc.op)
        tsc_pkg::OP_LOAD: begin
          if (accept) begin
            count_q <= (cnt_inc > len_c) ? CNT_W'(len_c) : CNT_W'(cnt_inc);
            ws_q    <= ws_next;
          end
        end
        tsc_pkg::OP_SETUP: begin
          k_q          <= '0;
          ptr_q        <= rd_next;
          n_q          <= NW'(n_c);
          tail_start_q <= CNT_W'(CMP_W'(count_q) - n_c);
        end
        tsc_pkg::OP_ACC: begin
          ptr_q <= rd_next;
          if (walk_more) begin
            k_q <= k_q + KW'(1);
          end
        end
        tsc_pkg::OP_DIVINIT: k_q <= '0;
        tsc_pkg::OP_DIVSTEP: begin
          if (div_more) begin
            k_q <= k_q + KW'(1);
          end
        end
        default: k_q <= k_q;
      endcase
    end
  end

  // motion ring
  entry_t ring_q [RING_DEPTH];
  entry_t rd_q;
  entry_t wr_entry;

  assign wr_entry = '{x: motion_i.shift_x, y: motion_i.shift_y,
                      a: {{(DW-AWID){motion_i.turn_angle[AWID-1]}}, motion_i.turn_angle}};

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ring_q[ws_q] <= wr_entry;
    end
    if (uc.op == tsc_pkg::OP_SETUP || uc.op == tsc_pkg::OP_ACC) begin
      rd_q <= ring_q[rd_addr];
    end
  end

  // lanes
  tsc_pkg::lane_ctl_t lane_ctl;

  always_comb begin
    lane_ctl          = '0;
    lane_ctl.load     = accept;
    lane_ctl.acc      = (uc.op == tsc_pkg::OP_ACC);
    lane_ctl.tail     = CMP_W'(k_q) >= CMP_W'(tail_start_q);
    lane_ctl.flush    = (uc.op == tsc_pkg::OP_FLUSH);
    lane_ctl.div_init = (uc.op == tsc_pkg::OP_DIVINIT);
    lane_ctl.div_step = (uc.op == tsc_pkg::OP_DIVSTEP);
    lane_ctl.sign     = (uc.op == tsc_pkg::OP_SIGN);
    lane_ctl.sum      = (uc.op == tsc_pkg::OP_SUM);
  end

  logic signed [DW-1:0]   res_x;
  logic signed [DW-1:0]   res_y;
  logic signed [AWID-1:0] res_a;

  tsc_lane #(.ACC_W(ACC_W), .SUM_W(SUM_W), .OUT_W(DW)) u_lane_x (
    .clk_i       (clk_i),
    .ctl_i       (lane_ctl),
    .new_data_i  (wr_entry.x),
    .ring_data_i (rd_q.x),
    .div_n_i     (n_q),
    .result_o    (res_x)
  );

  tsc_lane #(.ACC_W(ACC_W), .SUM_W(SUM_W), .OUT_W(DW)) u_lane_y (
    .clk_i       (clk_i),
    .ctl_i       (lane_ctl),
    .new_data_i  (wr_entry.y),
    .ring_data_i (rd_q.y),
    .div_n_i     (n_q),
    .result_o    (res_y)
  );

  tsc_lane #(.ACC_W(ACC_W), .SUM_W(SUM_W), .OUT_W(AWID)) u_lane_a (
    .clk_i       (clk_i),
    .ctl_i       (lane_ctl),
    .new_data_i  (wr_entry.a),
    .ring_data_i (rd_q.a),
    .div_n_i     (n_q),
    .result_o    (res_a)
  );

  // output register
  logic signed [DW-1:0]   out_x_q;
  logic signed [DW-1:0]   out_y_q;
  logic signed [AWID-1:0] out_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_fire) begin
      out_valid_q <= 1'b1;
    end else if (corr_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_x_q <= res_x;
      out_y_q <= res_y;
      out_a_q <= res_a;
    end
  end

  assign corr_o.valid           = out_valid_q;
  assign corr_o.corrected_x     = out_x_q;
  assign corr_o.corrected_y     = out_y_q;
  assign corr_o.corrected_angle = out_a_q;

  `TSC_ASSERT_NEXT(a_accept_to_setup, accept, step_q == tsc_pkg::STEP_SETUP, "accept did not start setup")
  `TSC_ASSERT_IMPLY(a_count_range, step_q != tsc_pkg::STEP_LOAD, count_q != '0 && CMP_W'(count_q) <= len_c, "stored count out of range")
  `TSC_ASSERT_IMPLY(a_walk_in_range, step_q == tsc_pkg::STEP_WALK, CMP_W'(k_q) < CMP_W'(count_q), "walk index past stored entries")
  `TSC_ASSERT_IMPLY(a_div_n_valid, step_q == tsc_pkg::STEP_DIVSTEP, n_q != '0 && CMP_W'(n_q) <= CMP_W'(count_q), "window size invalid during divide")
  `TSC_ASSERT_NEXT(a_emit_valid, emit_fire, out_valid_q, "emitted result not presented")

endmodule
